// ----- hw/rtl/kmp_pkg.sv -----
// Package for the KMP substring search block: command codes, defaults and
// the report record passed from the sequencer to the result stage.
// Depends on nothing.
package kmp_pkg;

  // Default pattern capacity in bytes.
  localparam int KMP_MAX_PATTERN = 64;

  // Command codes carried on the input channel.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } kmp_cmd_t;

  // Result of an end-of-text command.
  typedef struct packed {
    logic found;
    logic pattern_overflow;
  } kmp_report_t;

endpackage

// ----- hw/rtl/kmp_if.sv -----
// Channel interfaces for the KMP substring search block.
// kmp_in_if carries commands and bytes, kmp_out_if carries results; no dependencies.
interface kmp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] byte_value;

  modport source (output valid, output cmd, output byte_value, input ready);
  modport sink   (input valid, input cmd, input byte_value, output ready);
endinterface

interface kmp_out_if;
  logic valid;
  logic ready;
  logic found;
  logic pattern_overflow;

  modport source (output valid, output found, output pattern_overflow, input ready);
  modport sink   (input valid, input found, input pattern_overflow, output ready);
endinterface

// ----- hw/rtl/kmp_substring_search.sv -----
// KMP substring search: clear, append and text commands complete in the idle state when
// no walk is needed. A walk alternates a check state and a compare state for each failed
// compare, and ends on a byte match or when it runs off the start of the pattern. The
// single byte compare and the one read port on each RAM set this pacing. The end-of-text
// result is registered, so it appears the cycle after the transfer.
// Reset is synchronous and active low; it empties the pattern and clears both flags.
module kmp_substring_search
  import kmp_pkg::*;
#(
  parameter int MAX_PATTERN = KMP_MAX_PATTERN
) (
  input  logic clk,
  input  logic rst_n,
  kmp_in_if.sink    in_ch,
  kmp_out_if.source out_ch
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int PA = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic          out_free;
  logic          report_valid;
  kmp_report_t   report;
  logic          pat_we;
  logic [PA-1:0] pat_waddr;
  logic [7:0]    pat_wdata;
  logic [PA-1:0] pat_raddr;
  logic [7:0]    pat_rdata;
  logic          fail_we;
  logic [LW-1:0] fail_waddr;
  logic [LW-1:0] fail_wdata;
  logic [LW-1:0] fail_raddr;
  logic [LW-1:0] fail_rdata;
  logic          out_valid_r;
  kmp_report_t   out_data_r;

  kmp_seq #(
    .MAX_PATTERN(MAX_PATTERN),
    .LW(LW),
    .PA(PA)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_cmd      (in_ch.cmd),
    .in_byte     (in_ch.byte_value),
    .out_free    (out_free),
    .report_valid(report_valid),
    .report      (report),
    .pat_we      (pat_we),
    .pat_waddr   (pat_waddr),
    .pat_wdata   (pat_wdata),
    .pat_raddr   (pat_raddr),
    .pat_rdata   (pat_rdata),
    .fail_we     (fail_we),
    .fail_waddr  (fail_waddr),
    .fail_wdata  (fail_wdata),
    .fail_raddr  (fail_raddr),
    .fail_rdata  (fail_rdata)
  );

  // Pattern bytes.
  kmp_ram #(
    .DW(8),
    .DEPTH(MAX_PATTERN),
    .AW(PA)
  ) u_pat_ram (
    .clk  (clk),
    .we   (pat_we),
    .waddr(pat_waddr),
    .wdata(pat_wdata),
    .raddr(pat_raddr),
    .rdata(pat_rdata)
  );

  // Failure links; entry zero is implied as minus one and never read.
  kmp_ram #(
    .DW(LW),
    .DEPTH(MAX_PATTERN + 1),
    .AW(LW)
  ) u_fail_ram (
    .clk  (clk),
    .we   (fail_we),
    .waddr(fail_waddr),
    .wdata(fail_wdata),
    .raddr(fail_raddr),
    .rdata(fail_rdata)
  );

  // Output register; it frees up in the same cycle as its transfer.
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (report_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report_valid) begin
      out_data_r <= report;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.found            = out_data_r.found;
  assign out_ch.pattern_overflow = out_data_r.pattern_overflow;

endmodule

// ----- hw/rtl/kmp_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
// Used for the pattern store and the failure table; depends on nothing.
module kmp_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/kmp_seq.sv -----
// Sequencer of the KMP matcher: takes commands, walks failure links with one
// shared byte compare, and keeps length, build and match positions.
// Depends on kmp_pkg; drives the pattern and failure-table RAMs.
module kmp_seq
  import kmp_pkg::*;
#(
  parameter int MAX_PATTERN = KMP_MAX_PATTERN,
  parameter int LW = $clog2(MAX_PATTERN + 1),
  parameter int PA = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_cmd,
  input  logic [7:0]    in_byte,
  input  logic          out_free,
  output logic          report_valid,
  output kmp_report_t   report,
  output logic          pat_we,
  output logic [PA-1:0] pat_waddr,
  output logic [7:0]    pat_wdata,
  output logic [PA-1:0] pat_raddr,
  input  logic [7:0]    pat_rdata,
  output logic          fail_we,
  output logic [LW-1:0] fail_waddr,
  output logic [LW-1:0] fail_wdata,
  output logic [LW-1:0] fail_raddr,
  input  logic [LW-1:0] fail_rdata
);

  // Positions run from minus one up to the capacity.
  localparam int PW = LW + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CHK  = 3'b010,
    S_CMP  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic signed [PW-1:0] build_r, build_nxt;
  logic [LW-1:0]        match_r, match_nxt;
  logic                 found_r, found_nxt;
  logic                 ovf_r, ovf_nxt;
  logic signed [PW-1:0] j_r, j_nxt;
  logic [7:0]           chr_r, chr_nxt;
  logic                 append_r, append_nxt;

  kmp_cmd_t             cmd;
  logic                 accept;
  logic                 full;
  logic                 match_done;
  logic signed [PW-1:0] jp1;
  logic                 finish;

  assign cmd        = kmp_cmd_t'(in_cmd);
  assign full       = (len_r == LW'(MAX_PATTERN));
  assign match_done = (match_r >= len_r);
  assign jp1        = j_r + PW'(1);

  // Input is taken only between items; an end command also needs a free output slot.
  assign in_ready = (state_r == S_IDLE) && ((cmd != CMD_END) || out_free);
  assign accept   = in_valid && in_ready;

  // RAM addressing: writes of new pattern bytes and failure links, reads at j.
  assign pat_waddr  = len_r[PA-1:0];
  assign pat_wdata  = in_byte;
  assign pat_we     = accept && (cmd == CMD_APPEND) && !full;
  assign pat_raddr  = j_r[PA-1:0];
  assign fail_raddr = j_r[LW-1:0];
  assign fail_waddr = len_r + LW'(1);
  assign fail_wdata = jp1[LW-1:0];

  // The walk ends when j drops below zero or the compare hits.
  always_comb begin
    finish = 1'b0;
    if (state_r == S_CHK && j_r < 0) begin
      finish = 1'b1;
    end else if (state_r == S_CMP && pat_rdata == chr_r) begin
      finish = 1'b1;
    end
  end

  assign fail_we = finish && append_r;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    build_nxt    = build_r;
    match_nxt    = match_r;
    found_nxt    = found_r;
    ovf_nxt      = ovf_r;
    j_nxt        = j_r;
    chr_nxt      = chr_r;
    append_nxt   = append_r;
    report_valid = 1'b0;
    report.found            = found_r || match_done;
    report.pattern_overflow = ovf_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_CLEAR: begin
              len_nxt   = '0;
              build_nxt = '1;
              ovf_nxt   = 1'b0;
              match_nxt = '0;
              found_nxt = 1'b0;
            end
            CMD_APPEND: begin
              if (full) begin
                ovf_nxt = 1'b1;
              end else begin
                j_nxt      = build_r;
                chr_nxt    = in_byte;
                append_nxt = 1'b1;
                state_nxt  = S_CHK;
              end
            end
            CMD_TEXT: begin
              if (!found_r) begin
                if (match_done) begin
                  found_nxt = 1'b1;
                end else begin
                  j_nxt      = $signed({1'b0, match_r});
                  chr_nxt    = in_byte;
                  append_nxt = 1'b0;
                  state_nxt  = S_CHK;
                end
              end
            end
            CMD_END: begin
              report_valid = 1'b1;
              match_nxt    = '0;
              found_nxt    = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      // Reads of pattern[j] and failure[j] are in flight after this cycle.
      S_CHK: begin
        if (!finish) begin
          state_nxt = S_CMP;
        end
      end
      // Compare, or retreat along the failure link.
      S_CMP: begin
        if (!finish) begin
          if (j_r == '0) begin
            j_nxt = '1;
          end else begin
            j_nxt = $signed({1'b0, fail_rdata});
          end
          state_nxt = S_CHK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Commit the walk result.
    if (finish) begin
      state_nxt = S_IDLE;
      if (append_r) begin
        build_nxt = jp1;
        len_nxt   = len_r + LW'(1);
      end else begin
        match_nxt = jp1[LW-1:0];
        if (jp1[LW-1:0] >= len_r) begin
          found_nxt = 1'b1;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      build_r <= '1;
      match_r <= '0;
      found_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      build_r <= build_nxt;
      match_r <= match_nxt;
      found_r <= found_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Working registers of the walk.
  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    chr_r    <= chr_nxt;
    append_r <= append_nxt;
  end

endmodule

// ----- dv/kmp_search_checker.sv -----
// Checker for kmp_substring_search: watches both channels, predicts each search report
// and compares it with what the block returns. Depends on kmp_pkg and the channel
// interfaces in kmp_if.sv.
module kmp_search_checker
  import kmp_pkg::*;
#(
  parameter int MAX_PATTERN = KMP_MAX_PATTERN
) (
  input  logic      clk,
  input  logic      rst_n,
  kmp_in_if         in_ch,
  kmp_out_if        out_ch,
  output int        fail_count,
  output int        pending_results,
  output int        reports_checked,
  output int        hit_reports,
  output int        overflow_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted matcher state; positions are signed so that -1 marks "no prefix".
  logic [7:0] pat_mem [MAX_PATTERN];
  int         link_tab [MAX_PATTERN + 1];
  int         pat_len;
  int         build_pos;
  int         match_pos;
  bit         hit_flag;
  bit         drop_flag;

  // Reports still owed by the block, oldest first.
  kmp_report_t report_q[$];

  int errors;
  int checked;
  int hits;
  int drops;

  function automatic void clear_model();
    pat_len     = 0;
    build_pos   = -1;
    link_tab[0] = -1;
    drop_flag   = 1'b0;
    match_pos   = 0;
    hit_flag    = 1'b0;
  endfunction

  // Apply one command to the predicted state and return the report it causes, if any.
  function automatic void predict_report(input kmp_cmd_t c, input logic [7:0] b,
                                         output bit has_rep, output kmp_report_t rep);
    int j;
    has_rep = 1'b0;
    rep     = '0;
    case (c)
      CMD_CLEAR: begin
        clear_model();
      end
      CMD_APPEND: begin
        if (pat_len >= MAX_PATTERN) begin
          drop_flag = 1'b1;
        end else begin
          // Extend the failure table by one entry for the new byte.
          pat_mem[pat_len] = b;
          j = build_pos;
          while (j >= 0 && pat_mem[pat_len] != pat_mem[j]) j = link_tab[j];
          j++;
          link_tab[pat_len + 1] = j;
          build_pos = j;
          pat_len++;
        end
      end
      CMD_TEXT: begin
        // Once a hit is seen the rest of the text has no effect.
        if (!hit_flag) begin
          if (match_pos >= pat_len) begin
            hit_flag = 1'b1;
          end else begin
            j = match_pos;
            while (j >= 0 && b != pat_mem[j]) j = link_tab[j];
            j++;
            match_pos = j;
            if (j >= pat_len) hit_flag = 1'b1;
          end
        end
      end
      CMD_END: begin
        has_rep              = 1'b1;
        rep.found            = hit_flag || (match_pos >= pat_len);
        rep.pattern_overflow = drop_flag;
        match_pos            = 0;
        hit_flag             = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void note_failure(input string what, input logic want_v,
                                       input logic got_v);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] kmp checker: %s expected %b got %b", $realtime, what, want_v, got_v);
    end
  endfunction

  // Predict on every input transfer and check every output transfer.
  always @(posedge clk) begin
    kmp_report_t want;
    bit          has_rep;
    if (!rst_n) begin
      clear_model();
      report_q.delete();
      errors  = 0;
      checked = 0;
      hits    = 0;
      drops   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_report(kmp_cmd_t'(in_ch.cmd), in_ch.byte_value, has_rep, want);
        if (has_rep) report_q.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (report_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("[%0t] kmp checker: report with none outstanding (found %b overflow %b)",
                     $realtime, out_ch.found, out_ch.pattern_overflow);
          end
        end else begin
          want = report_q.pop_front();
          checked++;
          if (want.found) hits++;
          if (want.pattern_overflow) drops++;
          if (out_ch.found !== want.found) begin
            note_failure("found", want.found, out_ch.found);
          end
          if (out_ch.pattern_overflow !== want.pattern_overflow) begin
            note_failure("pattern_overflow", want.pattern_overflow, out_ch.pattern_overflow);
          end
        end
      end
    end
    fail_count       <= errors;
    pending_results  <= report_q.size();
    reports_checked  <= checked;
    hit_reports      <= hits;
    overflow_reports <= drops;
  end

endmodule

// ----- dv/kmp_substring_search_tb.sv -----
// Top of the kmp_substring_search testbench: clock, reset, command stimulus, output
// back-pressure and the verdict. Depends on kmp_pkg, kmp_if.sv, the block itself and
// kmp_search_checker.
module kmp_substring_search_tb;
  import kmp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_TARGET = 1350;
  localparam int LONG_HOLD     = 300;

  logic clk = 1'b0;
  logic rst_n;

  kmp_in_if  in_ch();
  kmp_out_if out_ch();

  int fail_count;
  int pending_results;
  int reports_checked;
  int hit_reports;
  int overflow_reports;

  int items_sent    = 0;
  int burst_left    = 0;
  int hold_requests = 0;

  kmp_substring_search i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  kmp_search_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .fail_count       (fail_count),
    .pending_results  (pending_results),
    .reports_checked  (reports_checked),
    .hit_reports      (hit_reports),
    .overflow_reports (overflow_reports)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one command and hold it until the block takes it. Commands go out in bursts
  // with random idle gaps in between.
  task automatic push_command(input kmp_cmd_t c, input logic [7:0] b);
    int idle_gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle_gap   = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : 0;
      if (idle_gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (idle_gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.byte_value <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every report owed has been returned.
  task automatic drain_reports();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    wait (pending_results == 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_symbol(input logic [7:0] alpha [4], input int n_sym,
                                             input bit wide);
    return wide ? 8'($urandom_range(0, 255)) : alpha[$urandom_range(0, n_sym - 1)];
  endfunction

  // One well-formed search: load a pattern over a small alphabet, or now and then any byte,
  // then run a few texts, each carrying the pattern at even odds, closed with an end of text.
  task automatic search_session();
    logic [7:0] alpha [4];
    logic [7:0] pat_q[$];
    logic [7:0] text_q[$];
    int  n_sym;
    int  plen;
    int  n_text;
    int  tlen;
    int  grow_at;
    bit  wide;
    logic [7:0] sym;
    n_sym = $urandom_range(2, 4);
    wide  = ($urandom_range(0, 7) == 0);
    foreach (alpha[k]) alpha[k] = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      7, 8:    plen = $urandom_range(7, 20);
      9:       plen = $urandom_range(KMP_MAX_PATTERN - 4, KMP_MAX_PATTERN + 4);
      default: plen = $urandom_range(1, 6);
    endcase
    // Now and then keep the old pattern and just extend it.
    if ($urandom_range(0, 9) != 0) push_command(CMD_CLEAR, 8'($urandom_range(0, 255)));
    for (int k = 0; k < plen; k++) begin
      sym = pick_symbol(alpha, n_sym, wide);
      pat_q.push_back(sym);
      push_command(CMD_APPEND, sym);
    end
    n_text = $urandom_range(1, 4);
    for (int t = 0; t < n_text; t++) begin
      text_q.delete();
      if ($urandom_range(0, 1) != 0) begin
        tlen = $urandom_range(0, 8);
        for (int k = 0; k < tlen; k++) text_q.push_back(pick_symbol(alpha, n_sym, wide));
        foreach (pat_q[k]) text_q.push_back(pat_q[k]);
        tlen = $urandom_range(0, 8);
        for (int k = 0; k < tlen; k++) text_q.push_back(pick_symbol(alpha, n_sym, wide));
      end else begin
        tlen = $urandom_range(0, (plen < 20) ? 3 * plen + 4 : plen + 8);
        for (int k = 0; k < tlen; k++) text_q.push_back(pick_symbol(alpha, n_sym, wide));
      end
      // Occasionally the pattern grows in the middle of a text.
      grow_at = ($urandom_range(0, 15) == 0) ? $urandom_range(0, text_q.size()) : -1;
      for (int k = 0; k <= text_q.size(); k++) begin
        if (k == grow_at) push_command(CMD_APPEND, pick_symbol(alpha, n_sym, wide));
        if (k < text_q.size()) push_command(CMD_TEXT, text_q[k]);
      end
      push_command(CMD_END, 8'($urandom_range(0, 255)));
    end
  endtask

  // Output back-pressure: ready follows one of several patterns, switched at random now and
  // then, plus a long hold-off whenever the stimulus asks for one.
  initial begin
    int mode;
    int left;
    int holds_done;
    out_ch.ready = 1'b0;
    mode       = 0;
    left       = 0;
    holds_done = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 128);
      end
      left--;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= ((left % 4) != 0);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Stimulus and verdict.
  initial begin
    int session;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_CLEAR;
    in_ch.byte_value = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty pattern after reset: empty text and a short text both match.
    push_command(CMD_END, 8'h00);
    push_command(CMD_TEXT, 8'h00);
    push_command(CMD_TEXT, 8'hFF);
    push_command(CMD_END, 8'hFF);
    // Two-byte pattern with no text, then a match that needs a failure link.
    push_command(CMD_CLEAR, 8'hFF);
    push_command(CMD_APPEND, 8'hFF);
    push_command(CMD_APPEND, 8'h00);
    push_command(CMD_END, 8'h00);
    push_command(CMD_TEXT, 8'hFF);
    push_command(CMD_TEXT, 8'hFF);
    push_command(CMD_TEXT, 8'h00);
    // Text after the hit is ignored.
    push_command(CMD_TEXT, 8'hAA);
    push_command(CMD_END, 8'h00);
    // Pattern grows while a text is under way.
    push_command(CMD_TEXT, 8'hFF);
    push_command(CMD_APPEND, 8'h5A);
    push_command(CMD_TEXT, 8'h00);
    push_command(CMD_TEXT, 8'h5A);
    push_command(CMD_END, 8'hFF);
    // Clear brings back the empty pattern.
    push_command(CMD_CLEAR, 8'h00);
    push_command(CMD_TEXT, 8'h0F);
    push_command(CMD_END, 8'hF0);

    session = 0;
    while (items_sent < RANDOM_TARGET) begin
      session++;
      if (session == 4 || session == 20) begin
        // Long output hold-off while end-of-text commands keep coming.
        hold_requests++;
        repeat (10) begin
          push_command(CMD_TEXT, 8'($urandom_range(0, 255)));
          push_command(CMD_END, 8'($urandom_range(0, 255)));
        end
      end else if (session % 9 == 0) begin
        drain_reports();
        search_session();
      end else if ($urandom_range(0, 9) == 0) begin
        // Unstructured commands.
        repeat ($urandom_range(5, 15)) begin
          push_command(kmp_cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
        push_command(CMD_END, 8'($urandom_range(0, 255)));
      end else begin
        search_session();
      end
    end

    drain_reports();
    repeat (20) @(posedge clk);
    $display("Sent %0d commands over %0d sessions; checked %0d reports, %0d hits, %0d overflows.",
             items_sent, session, reports_checked, hit_reports, overflow_reports);
    if (fail_count == 0 && pending_results == 0) begin
      $display("kmp_substring_search_tb: clean");
    end else begin
      $display("kmp_substring_search_tb: errors");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #12_000_000;
    $display("kmp_substring_search_tb: errors");
    $finish;
  end

endmodule
